FILE: rtl/core/lkvc_pkg.sv
// Package for the LRU key/value cache.
// Holds field widths, operation codes, reset constants and the sequencer state type.
// No dependencies.
package lkvc_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } lkvc_state_e;

endpackage

FILE: rtl/core/lru_key_value_cache.sv
// Top level of the fully associative key/value cache with LRU replacement.
// Depends on lkvc_pkg and instantiates lkvc_ram for keys/values and ranks.

// One item is a get or a put of a 32-bit key. The block takes one item at a
// time. A sequencer walks the single read port of each RAM over all entries:
// once to compare every stored key against the item's key (tracking the first
// hit, the least recent valid entry and the first free entry), and, for a
// hit, a put miss that inserts or a put miss that evicts, once more to read
// every recency rank and write back those that change; a get miss needs only
// the first pass. A finished result sits in an output register, so the next
// item is accepted while that result waits to be taken. The user must write
// the capacity register through cfg_we_i/cfg_wdata_i only while the block is
// idle; the block itself does not enforce this. A capacity of zero acts as one
// and one above ENTRIES acts as ENTRIES. Keys, values and ranks live in RAM
// without reset; per-entry valid bits and the occupancy count are cleared by
// reset, so no clearing pass is needed.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CAP_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    operation_i,
  input  logic [KEY_W-1:0]        lookup_key_i,
  input  logic signed [VAL_W-1:0] write_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    found_o,
  output logic signed [VAL_W-1:0] read_value_o,
  output logic                    evicted_o
);

  // Index and rank width; a rank never exceeds ENTRIES-1.
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // Occupancy counts up to ENTRIES itself.
  localparam int unsigned OW = $clog2(ENTRIES + 1);
  // Common width for capacity and occupancy compares.
  localparam int unsigned CW = (OW > CAP_W) ? OW : CAP_W;
  localparam int unsigned KVW = KEY_W + VAL_W;

  localparam logic [IW:0] CNT_END = (IW + 1)'(ENTRIES);

  lkvc_state_e state_q, state_d;

  logic [IW:0]        cnt_q, cnt_d;
  logic               rd_pend_q, rd_pend_d;
  logic [IW-1:0]      rd_idx_q, rd_idx_d;

  logic               op_q, op_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [VAL_W-1:0]   wval_q, wval_d;

  logic               hit_q, hit_d;
  logic [IW-1:0]      hit_idx_q, hit_idx_d;
  logic [IW-1:0]      hit_rank_q, hit_rank_d;
  logic [VAL_W-1:0]   hit_val_q, hit_val_d;
  logic               lru_any_q, lru_any_d;
  logic [IW-1:0]      lru_idx_q, lru_idx_d;
  logic [IW-1:0]      lru_rank_q, lru_rank_d;
  logic               free_any_q, free_any_d;
  logic [IW-1:0]      free_idx_q, free_idx_d;

  logic [IW-1:0]      slot_q, slot_d;
  logic               ins_q, ins_d;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [OW-1:0]      occ_q, occ_d;
  logic [CAP_W-1:0]   cap_q, cap_d;

  logic               res_found_q, res_found_d;
  logic [VAL_W-1:0]   res_rd_q, res_rd_d;
  logic               res_ev_q, res_ev_d;

  logic               out_valid_q, out_valid_d;
  logic               out_found_q, out_found_d;
  logic [VAL_W-1:0]   out_rd_q, out_rd_d;
  logic               out_ev_q, out_ev_d;

  // RAM ports.
  logic               kv_we;
  logic [IW-1:0]      kv_waddr;
  logic [KVW-1:0]     kv_wdata;
  logic [KVW-1:0]     kv_rdata;
  logic               rk_we;
  logic [IW-1:0]      rk_waddr;
  logic [IW-1:0]      rk_wdata;
  logic [IW-1:0]      rk_rdata;
  logic [IW-1:0]      raddr;

  logic               in_acc;
  logic               issue;
  logic               pass_last;
  logic               out_load;

  logic [CW-1:0]      cap_ext;
  logic [CW-1:0]      eff_cap;
  logic               dec_evict;
  logic [IW-1:0]      dec_slot;
  logic               dec_slot_ok;

  logic               ent_valid;
  logic               key_match;
  logic               self_slot;
  logic               rank_inc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Both passes issue one read per cycle until the counter reaches ENTRIES;
  // the registered data for that index shows up in the next cycle.
  assign issue     = (cnt_q < CNT_END);
  assign pass_last = rd_pend_q && (cnt_q == CNT_END);
  assign raddr     = cnt_q[IW-1:0];

  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Entry under examination in either pass.
  assign ent_valid = valid_q[rd_idx_q];
  assign key_match = ent_valid && (kv_rdata[KVW-1:VAL_W] == key_q);
  assign self_slot = (rd_idx_q == slot_q);
  // A touch ages only entries younger than the touched one; an insert ages all.
  assign rank_inc  = ent_valid && (ins_q || (rk_rdata < hit_rank_q));

  // Capacity clamped into the range one to ENTRIES.
  assign cap_ext = CW'(cap_q);
  always_comb begin
    priority if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // A put miss evicts the least recent entry when the cache is full,
  // otherwise it takes the lowest free entry.
  assign dec_evict   = (CW'(occ_q) >= eff_cap) && (occ_q != '0) && lru_any_q;
  assign dec_slot    = dec_evict ? lru_idx_q : free_idx_q;
  assign dec_slot_ok = dec_evict || free_any_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (pass_last) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (hit_q || (op_q == OP_PUT && dec_slot_ok)) begin
          state_d = ST_UPDATE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_UPDATE: begin
        if (pass_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // RAM write controls.
  always_comb begin
    kv_we    = 1'b0;
    kv_waddr = hit_idx_q;
    kv_wdata = {key_q, wval_q};
    rk_we    = 1'b0;
    rk_waddr = rd_idx_q;
    rk_wdata = self_slot ? '0 : (rank_inc ? rk_rdata + IW'(1) : rk_rdata);
    unique case (state_q)
      ST_DECIDE: begin
        if (op_q == OP_PUT) begin
          if (hit_q) begin
            kv_we = 1'b1;
          end else if (dec_slot_ok) begin
            kv_we    = 1'b1;
            kv_waddr = dec_slot;
          end
        end
      end
      ST_UPDATE: begin
        rk_we = rd_pend_q && (self_slot || rank_inc);
      end
      ST_IDLE, ST_SCAN, ST_DONE: begin
        kv_we = 1'b0;
      end
      default: kv_we = 1'b0;
    endcase
  end

  // Datapath next values.
  always_comb begin
    cnt_d       = cnt_q;
    rd_pend_d   = rd_pend_q;
    rd_idx_d    = rd_idx_q;
    op_d        = op_q;
    key_d       = key_q;
    wval_d      = wval_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_rank_d  = hit_rank_q;
    hit_val_d   = hit_val_q;
    lru_any_d   = lru_any_q;
    lru_idx_d   = lru_idx_q;
    lru_rank_d  = lru_rank_q;
    free_any_d  = free_any_q;
    free_idx_d  = free_idx_q;
    slot_d      = slot_q;
    ins_d       = ins_q;
    valid_d     = valid_q;
    occ_d       = occ_q;
    cap_d       = cfg_we_i ? cfg_wdata_i : cap_q;
    res_found_d = res_found_q;
    res_rd_d    = res_rd_q;
    res_ev_d    = res_ev_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_found_d = out_found_q;
    out_rd_d    = out_rd_q;
    out_ev_d    = out_ev_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d       = operation_i;
          key_d      = lookup_key_i;
          wval_d     = write_value_i;
          cnt_d      = '0;
          rd_pend_d  = 1'b0;
          hit_d      = 1'b0;
          lru_any_d  = 1'b0;
          free_any_d = 1'b0;
        end
      end
      ST_SCAN, ST_UPDATE: begin
        rd_pend_d = issue;
        rd_idx_d  = raddr;
        if (issue) cnt_d = cnt_q + (IW + 1)'(1);
        if (state_q == ST_SCAN && rd_pend_q) begin
          if (key_match && !hit_q) begin
            hit_d      = 1'b1;
            hit_idx_d  = rd_idx_q;
            hit_rank_d = rk_rdata;
            hit_val_d  = kv_rdata[VAL_W-1:0];
          end
          if (ent_valid && (!lru_any_q || rk_rdata > lru_rank_q)) begin
            lru_any_d  = 1'b1;
            lru_idx_d  = rd_idx_q;
            lru_rank_d = rk_rdata;
          end
          if (!ent_valid && !free_any_q) begin
            free_any_d = 1'b1;
            free_idx_d = rd_idx_q;
          end
        end
      end
      ST_DECIDE: begin
        cnt_d     = '0;
        rd_pend_d = 1'b0;
        res_rd_d  = '0;
        res_ev_d  = 1'b0;
        if (hit_q) begin
          res_found_d = 1'b1;
          if (op_q == OP_GET) res_rd_d = hit_val_q;
          slot_d = hit_idx_q;
          ins_d  = 1'b0;
        end else begin
          res_found_d = 1'b0;
          if (op_q == OP_PUT && dec_slot_ok) begin
            // An eviction frees the slot that the new entry takes at once,
            // so occupancy only grows when a free entry is used.
            res_ev_d          = dec_evict;
            slot_d            = dec_slot;
            ins_d             = 1'b1;
            valid_d[dec_slot] = 1'b1;
            if (!dec_evict) occ_d = occ_q + OW'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_rd_d    = res_rd_q;
          out_ev_d    = res_ev_q;
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      valid_q     <= '0;
      occ_q       <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_pend_q   <= rd_pend_d;
      valid_q     <= valid_d;
      occ_q       <= occ_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    op_q        <= op_d;
    key_q       <= key_d;
    wval_q      <= wval_d;
    hit_q       <= hit_d;
    hit_idx_q   <= hit_idx_d;
    hit_rank_q  <= hit_rank_d;
    hit_val_q   <= hit_val_d;
    lru_any_q   <= lru_any_d;
    lru_idx_q   <= lru_idx_d;
    lru_rank_q  <= lru_rank_d;
    free_any_q  <= free_any_d;
    free_idx_q  <= free_idx_d;
    slot_q      <= slot_d;
    ins_q       <= ins_d;
    res_found_q <= res_found_d;
    res_rd_q    <= res_rd_d;
    res_ev_q    <= res_ev_d;
    out_found_q <= out_found_d;
    out_rd_q    <= out_rd_d;
    out_ev_q    <= out_ev_d;
  end

  // Keys in the upper half, values in the lower half.
  lkvc_ram #(
    .WIDTH(KVW),
    .DEPTH(ENTRIES)
  ) u_kv_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .waddr_i (kv_waddr),
    .wdata_i (kv_wdata),
    .raddr_i (raddr),
    .rdata_o (kv_rdata)
  );

  // Recency ranks: 0 is the most recent valid entry.
  lkvc_ram #(
    .WIDTH(IW),
    .DEPTH(ENTRIES)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rk_we),
    .waddr_i (rk_waddr),
    .wdata_i (rk_wdata),
    .raddr_i (raddr),
    .rdata_o (rk_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign found_o      = out_found_q;
  assign read_value_o = out_rd_q;
  assign evicted_o    = out_ev_q;

  // The occupancy count always matches the number of valid entries.
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == occ_q)
    else $error("occupancy does not match valid entries");

  // Occupancy and valid bits only move when an item is resolved.
  a_occ_changes_in_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_DECIDE |=> $stable(occ_q) && $stable(valid_q))
    else $error("occupancy changed outside the decision step");

  // An eviction only happens on a put that missed.
  a_evict_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |-> !found_o)
    else $error("eviction reported on a hit");

  // A miss never returns a value.
  a_miss_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> read_value_o == '0)
    else $error("nonzero value on a miss");

  // Rank writes happen only during the rank pass.
  a_rank_write_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rk_we |-> state_q == ST_UPDATE && rd_pend_q)
    else $error("rank written outside the rank pass");

endmodule

FILE: rtl/core/lkvc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the key/value store and the recency ranks; no dependencies.
module lkvc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/tb_lru_key_value_cache.sv
// Self-checking testbench for lru_key_value_cache: a scoreboard class predicts every result.
// Depends on lkvc_pkg and the lru_key_value_cache RTL; needs no files or arguments.
// Stimulus is directed and then random; idle gaps fall on both sides of the block.
module tb_lru_key_value_cache
  import lkvc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES = 16;
  // A hit or any put makes both passes over the entries inside the block. Once the
  // last result has been taken, we wait as long as one such item before the final verdict.
  localparam int unsigned ITEM_CYCLES = 2 * ENTRIES + 5;
  // This is the long stretch in which the receiver takes no results. It is long
  // enough that the output register and the sequencer both fill up, so the block
  // has to hold off the sender.
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 130;
  localparam int unsigned N_PHASES = 7;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
  } cache_result_t;

  // The scoreboard holds its own copy of the cache: the keys, the values, the
  // valid bits, a recency age per entry (0 means newest) and the number of
  // entries in use. note_request works out the result that each accepted
  // item must produce and queues it. check_response compares each accepted
  // result with the oldest queued one.
  class cache_scoreboard;
    bit [KEY_W-1:0]  slot_key   [ENTRIES];
    bit [VAL_W-1:0]  slot_value [ENTRIES];
    bit              slot_live  [ENTRIES];
    int unsigned     slot_age   [ENTRIES];
    int unsigned     live_count;
    bit [CAP_W-1:0]  capacity;
    cache_result_t   expected_q [$];
    int unsigned     error_count;

    function new();
      foreach (slot_live[i]) begin
        slot_live[i] = 1'b0;
        slot_age[i]  = 0;
      end
      live_count  = 0;
      capacity    = CAP_RESET;
      error_count = 0;
    endfunction

    function void set_capacity(bit [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_request(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
      int          hit_slot;
      int          victim;
      int unsigned usable;
      int unsigned oldest_age;
      int unsigned pivot;
      cache_result_t res;
      hit_slot = -1;
      victim   = -1;
      res      = '0;

      for (int i = 0; i < ENTRIES; i++)
        if (hit_slot < 0 && slot_live[i] && slot_key[i] == key) hit_slot = i;

      if (hit_slot >= 0) begin
        res.found = 1'b1;
        if (op == OP_PUT) slot_value[hit_slot] = value;
        else res.read_value = slot_value[hit_slot];
        // The hit entry becomes the newest. Entries that were newer than it age by one.
        pivot = slot_age[hit_slot];
        for (int i = 0; i < ENTRIES; i++)
          if (slot_live[i] && i != hit_slot && slot_age[i] < pivot) slot_age[i]++;
        slot_age[hit_slot] = 0;
      end else if (op == OP_PUT) begin
        // A capacity of zero acts as one. A capacity above the entry count acts as full size.
        usable = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : capacity;
        // The capacity may have been lowered while entries are held. Then only one
        // entry goes per put miss, so the occupancy stays where it is.
        if (live_count >= usable && live_count > 0) begin
          oldest_age = 0;
          for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i] && (victim < 0 || slot_age[i] > oldest_age)) begin
              victim     = i;
              oldest_age = slot_age[i];
            end
          if (victim >= 0) begin
            slot_live[victim] = 1'b0;
            live_count--;
            res.evicted = 1'b1;
          end
        end
        if (victim < 0)
          for (int i = 0; i < ENTRIES; i++)
            if (victim < 0 && !slot_live[i]) victim = i;
        if (victim >= 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i]) slot_age[i]++;
          slot_key[victim]   = key;
          slot_value[victim] = value;
          slot_live[victim]  = 1'b1;
          slot_age[victim]   = 0;
          live_count++;
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_response(logic found, logic signed [VAL_W-1:0] rd, logic evicted);
      cache_result_t exp_res;
      if (expected_q.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing expected: found=%0b read_value=%0d evicted=%0b",
                 $time, found, rd, evicted);
        return;
      end
      exp_res = expected_q.pop_front();
      if (found !== exp_res.found) begin
        error_count++;
        $display("%0t: found mismatch: expected %0b, actual %0b", $time, exp_res.found, found);
      end
      if (rd !== exp_res.read_value) begin
        error_count++;
        $display("%0t: read_value mismatch: expected %0d, actual %0d",
                 $time, exp_res.read_value, rd);
      end
      if (evicted !== exp_res.evicted) begin
        error_count++;
        $display("%0t: evicted mismatch: expected %0b, actual %0b",
                 $time, exp_res.evicted, evicted);
      end
    endfunction
  endclass

  // Every input of the block has a known value from time zero.
  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    cfg_we    = 1'b0;
  logic [CAP_W-1:0]        cfg_wdata = '0;
  logic                    req_valid = 1'b0;
  logic                    req_ready;
  logic                    req_op    = OP_GET;
  logic [KEY_W-1:0]        req_key   = '0;
  logic signed [VAL_W-1:0] req_value = '0;
  logic                    rsp_valid;
  logic                    rsp_ready = 1'b0;
  logic                    rsp_found;
  logic signed [VAL_W-1:0] rsp_value;
  logic                    rsp_evicted;

  // These flags shape the idling. idle_en switches the random gaps on both
  // sides. hold_request asks the receiver process for one long hold-off.
  bit          idle_en      = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned stall_left   = 0;

  logic [KEY_W-1:0] key_pool [24];
  // Each random phase runs with one of these capacities. The extremes are
  // among them: 0 acts as 1, and 31 acts as ENTRIES.
  logic [CAP_W-1:0] phase_cap [N_PHASES] = '{5'd16, 5'd1, 5'd31, 5'd7, 5'd0, 5'd3, 5'd16};

  cache_scoreboard cache_sb = new();

  lru_key_value_cache #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (req_valid),
    .in_ready_o   (req_ready),
    .operation_i  (req_op),
    .lookup_key_i (req_key),
    .write_value_i(req_value),
    .out_valid_o  (rsp_valid),
    .out_ready_i  (rsp_ready),
    .found_o      (rsp_found),
    .read_value_o (rsp_value),
    .evicted_o    (rsp_evicted)
  );

  always #5 clk = ~clk;

  // Both handshakes are sampled at the rising edge. The testbench drives every
  // input at the falling edge, so these values are stable here. The result is
  // checked before the new item is noted. An item and the result it causes can
  // never share an edge, so the order only keeps the queue easy to read.
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_valid && rsp_ready) cache_sb.check_response(rsp_found, rsp_value, rsp_evicted);
      if (req_valid && req_ready) cache_sb.note_request(req_op, req_key, req_value);
    end
  end

  // The receiver. A long hold-off that was asked for comes first. Otherwise it
  // stalls now and then at random, while idling is on.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ready = 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      rsp_ready  = 1'b0;
    end else begin
      rsp_ready = 1'b1;
    end
  end

  // This task offers one item and returns at the edge that accepts it. Valid
  // stays high from one item to the next unless a gap is inserted. That way
  // the signal is never lowered and raised again in the same step.
  task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                           input logic signed [VAL_W-1:0] value);
    int unsigned gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 99) < 25) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      @(negedge clk);
      req_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid = 1'b1;
    req_op    = op;
    req_key   = key;
    req_value = value;
    do @(posedge clk); while (!req_ready);
  endtask

  // A capacity write happens only when the block is idle. By then every
  // expected result has arrived and valid is low. Every item yields a result,
  // so nothing is left in flight at that point.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk);
    req_valid = 1'b0;
    while (cache_sb.pending() != 0) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = cap;
    cache_sb.set_capacity(cap);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One random phase. The keys come mostly from a small pool. The pool is one
  // to six keys larger than the usable capacity, so hits, misses and evictions
  // all happen often. The pool always holds the all-zero and all-one keys.
  // The rest are fully random 32-bit keys.
  task automatic run_random_phase(input int unsigned n_items, input logic [CAP_W-1:0] cap);
    int unsigned      usable;
    int unsigned      pool_n;
    logic             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    usable = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
    pool_n = usable + $urandom_range(1, 6);
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < pool_n; i++) key_pool[i] = $urandom;
    for (int n = 0; n < n_items; n++) begin
      op  = $urandom_range(0, 1) ? OP_PUT : OP_GET;
      key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, pool_n - 1)] : $urandom;
      case ($urandom_range(0, 11))
        0:       value = 32'h7FFF_FFFF;
        1:       value = 32'h8000_0000;
        2:       value = '0;
        3:       value = '1;
        default: value = $urandom;
      endcase
      send_item(op, key, value);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed part with two usable entries. It covers a get miss, inserts of
    // the extreme keys and values, a hit that changes the recency order, and an
    // eviction of the least recent entry. It also covers an update of a present
    // key and a get whose write value is ignored.
    write_capacity(5'd2);
    send_item(OP_GET, 32'h0000_0000, 32'h1234_5678);
    send_item(OP_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
    send_item(OP_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
    send_item(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_PUT, 32'h0000_0005, 32'hFFFF_FFFF);
    send_item(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_GET, 32'h0000_0005, 32'h0000_0000);
    send_item(OP_GET, 32'h0000_0000, 32'h5555_5555);
    send_item(OP_PUT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);

    // A capacity of zero acts as one, and here it is written while two entries
    // are held. Each later put miss removes exactly one entry, so the
    // occupancy stays at two.
    write_capacity(5'd0);
    send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_PUT, 32'h0000_0001, 32'h0000_0001);
    send_item(OP_PUT, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_GET, 32'h0000_0001, 32'h0000_0000);
    send_item(OP_PUT, 32'h8000_0000, 32'h0000_0007);

    // Random phases go through a range of capacities. The fourth phase opens
    // with the long receiver hold-off, while the sender keeps offering items.
    // The last phase runs with no idling on either side.
    for (int p = 0; p < N_PHASES; p++) begin
      write_capacity(phase_cap[p]);
      if (p == 3) hold_request = 1'b1;
      if (p == N_PHASES - 1) idle_en = 1'b0;
      run_random_phase(PHASE_ITEMS, phase_cap[p]);
    end

    @(negedge clk);
    req_valid = 1'b0;
    while (cache_sb.pending() != 0) @(posedge clk);
    // Any stray result would show up within one more item time.
    repeat (ITEM_CYCLES) @(posedge clk);

    if (cache_sb.error_count == 0 && cache_sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // This limit lies well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
